@@ src/dialog_id_ring_allocator_macros.svh @@
// assertion macros of the allocator rtl
`ifndef DIALOG_ID_RING_ALLOCATOR_MACROS_SVH
`define DIALOG_ID_RING_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DIRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dira_pkg.sv @@
// types and constants of the dialog id ring allocator
package dira_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 13;
  localparam int POOL_W   = 13;
  localparam int SHIFT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 12;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // stream packing
  localparam int S_CMD_LSB  = 0;
  localparam int S_ID_LSB   = S_CMD_LSB + CMD_W;
  localparam int S_TDATA_W  = 16;
  localparam int M_STAT_LSB = 0;
  localparam int M_ID_LSB   = M_STAT_LSB + STATUS_W;
  localparam int M_USE_LSB  = M_ID_LSB + ID_W;
  localparam int M_FREE_LSB = M_USE_LSB + COUNT_W;
  localparam int M_TDATA_W  = 40;

  localparam logic [COUNT_W-1:0] OUTST_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_REG   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_INVALID  = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_SIZE = 1'b0,
    CFG_SHIFT     = 1'b1
  } cfg_idx_e;

endpackage

@@ src/dialog_id_ring_allocator.sv @@
// dialog id ring allocator: free-slot ring, in-use bit store and command sequencer
// flow: accept, then execute against registered memory reads, one command at a time;
//   an allocate that lands on emptied ring entries steps through walk read and walk check
//   per entry skipped, bounded by the ring depth; the skip walk re-uses the single
//   usable-slot checker; the result is registered, and a new one waits until m_axis takes it
// reset: a clearing pass reloads the ring and clears the in-use bits;
//   s_axis_tready stays low until it ends, config writes are taken throughout
module dialog_id_ring_allocator #(
  parameter int POOL_DEPTH = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [dira_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dira_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // command items in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dira_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // cmd, dlg_id, zero pad
  // result items out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dira_pkg::M_TDATA_W-1:0]   m_axis_tdata   // status, alloc_id, in_use_count,
                                                          // free_count, zero pad
);
  import dira_pkg::*;

  `include "dialog_id_ring_allocator_macros.svh"

  // ring holds slot numbers 1..cap, entry 0 unused; 0 in an entry means emptied
  localparam int RING_DEPTH = POOL_DEPTH / 2 + 1;
  localparam int RW         = $clog2(RING_DEPTH);
  localparam int IN_DEPTH   = POOL_DEPTH + 1;
  localparam int IW         = $clog2(IN_DEPTH);
  localparam int SW         = ((RW > POOL_W) ? RW : POOL_W) + 1;
  localparam int HALF_W     = POOL_W - 1;

  typedef enum logic [4:0] {
    S_CLEAR    = 5'b00001,
    S_IDLE     = 5'b00010,
    S_EXEC     = 5'b00100,
    S_WALK_RD  = 5'b01000,
    S_WALK_CHK = 5'b10000
  } state_e;

  // ring pointer step: wraps past cap (or past the ring end) back to slot 1
  function automatic logic [RW-1:0] advance(input logic [RW-1:0] p,
                                            input logic [HALF_W-1:0] cap);
    logic [RW:0] nxt;
    nxt = (RW+1)'(p) + (RW+1)'(1);
    if ((32'(nxt) > 32'(cap)) || (32'(nxt) >= RING_DEPTH)) begin
      return RW'(1);
    end
    return nxt[RW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // config regs, derived bounds (registered); user keeps config quiet when busy, not enforced
  // ---------------------------------------------------------------------------
  logic [POOL_W-1:0]  pool_size_q;
  logic [SHIFT_W-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_W'(4096);
      shift_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_SIZE: pool_size_q <= cfg_data_i;
        CFG_SHIFT:     shift_q     <= cfg_data_i[SHIFT_W-1:0];
        default:       ;
      endcase
    end
  end

  logic [POOL_W-1:0] pool_eff_d, pool_eff_q;   // highest valid id
  logic [HALF_W-1:0] half_d, shift_eff_d;
  logic [POOL_W-1:0] base_d, base_q;           // allocated id = slot + base
  logic [HALF_W-1:0] cap_d, cap_q;             // ring capacity

  always_comb begin
    pool_eff_d  = (32'(pool_size_q) > POOL_DEPTH) ? POOL_W'(POOL_DEPTH) : pool_size_q;
    half_d      = pool_eff_d[POOL_W-1:1];
    shift_eff_d = (HALF_W'(shift_q) > half_d) ? half_d : HALF_W'(shift_q);
    base_d      = POOL_W'(half_d) + POOL_W'(shift_eff_d);
    cap_d       = half_d - shift_eff_d;
  end

  always_ff @(posedge clk_i) begin
    pool_eff_q <= pool_eff_d;
    base_q     <= base_d;
    cap_q      <= cap_d;
  end

  // ---------------------------------------------------------------------------
  // memories: free ring and in-use bits, one write and one registered read each
  // ---------------------------------------------------------------------------
  logic [RW-1:0] ring_mem [RING_DEPTH];
  logic          ring_we;
  logic [RW-1:0] ring_waddr, ring_wdata;
  logic [RW-1:0] ring_rd_q;

  logic          in_use_mem [IN_DEPTH];
  logic          in_use_we;
  logic [IW-1:0] in_use_waddr, in_use_raddr;
  logic          in_use_wdata;
  logic          in_use_rd_q;

  logic [RW-1:0] take_q, take_d;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rd_q <= ring_mem[take_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_use_we) begin
      in_use_mem[in_use_waddr] <= in_use_wdata;
    end
    in_use_rd_q <= in_use_mem[in_use_raddr];
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [IW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [RW-1:0]     ret_q, ret_d;
  logic [RW-1:0]     start_q, start_d;
  logic [RW-1:0]     walk_cnt_q, walk_cnt_d;
  logic [COUNT_W-1:0] outst_q, outst_d;
  cmd_e              cmd_q;
  logic [ID_W-1:0]   id_q;

  logic              s_accept;
  logic              out_free;
  logic              push;
  status_e           res_status;
  logic [ID_W-1:0]   res_id;

  // shared slot checker, run on whatever ring entry the pointer read last
  logic [SW-1:0]     slot_sum;
  logic              slot_ok;
  logic              id_ok;
  logic [RW-1:0]     adv_take, adv_ret;

  // output register
  logic              m_valid_q;
  status_e           m_status_q;
  logic [ID_W-1:0]   m_id_q;
  logic [COUNT_W-1:0] m_use_q, m_free_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign slot_sum = SW'(ring_rd_q) + SW'(base_q);
  assign slot_ok  = (ring_rd_q != '0) && (slot_sum <= SW'(pool_eff_q));
  assign id_ok    = (id_q != '0) && (id_q <= pool_eff_q);
  assign adv_take = advance(take_q, cap_q);
  assign adv_ret  = advance(ret_q, cap_q);

  // idle reads the bit of the incoming id so that it is registered when execute starts
  assign in_use_raddr = (state_q == S_IDLE) ? IW'(s_axis_tdata[S_ID_LSB +: ID_W]) : IW'(id_q);

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    take_d       = take_q;
    ret_d        = ret_q;
    start_d      = start_q;
    walk_cnt_d   = walk_cnt_q;
    outst_d      = outst_q;
    push         = 1'b0;
    res_status   = STAT_OK;
    res_id       = '0;
    ring_we      = 1'b0;
    ring_waddr   = take_q;
    ring_wdata   = '0;
    in_use_we    = 1'b0;
    in_use_waddr = IW'(id_q);
    in_use_wdata = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ring_we      = (32'(clr_cnt_q) < RING_DEPTH);
        ring_waddr   = clr_cnt_q[RW-1:0];
        ring_wdata   = clr_cnt_q[RW-1:0];
        in_use_we    = 1'b1;
        in_use_waddr = clr_cnt_q;
        in_use_wdata = 1'b0;
        clr_cnt_d    = clr_cnt_q + IW'(1);
        if (clr_cnt_q == IW'(POOL_DEPTH)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_accept) begin
          walk_cnt_d = '0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          case (cmd_q)
            CMD_ALLOC: begin
              if (cap_q == '0) begin
                push       = 1'b1;
                res_status = STAT_FULL;
              end else if (slot_ok) begin
                // take the slot under the pointer
                push         = 1'b1;
                res_id       = ID_W'(slot_sum);
                ring_we      = 1'b1;
                in_use_we    = 1'b1;
                in_use_waddr = IW'(slot_sum);
                in_use_wdata = 1'b1;
                take_d       = adv_take;
                outst_d      = (outst_q != OUTST_MAX) ? outst_q + COUNT_W'(1) : outst_q;
              end else if (outst_q >= cap_q) begin
                push       = 1'b1;
                res_status = STAT_FULL;
              end else begin
                // emptied entry: walk the ring one entry at a time
                start_d = take_q;
                take_d  = adv_take;
                state_d = S_WALK_RD;
              end
            end
            CMD_FREE: begin
              push = 1'b1;
              if (!id_ok) begin
                res_status = STAT_INVALID;
              end else if (!in_use_rd_q) begin
                res_status = STAT_NOT_USED;
              end else begin
                in_use_we = 1'b1;
                if (id_q > base_q) begin
                  // upper range id goes back into the ring
                  ring_we    = 1'b1;
                  ring_waddr = ret_q;
                  ring_wdata = RW'(id_q - base_q);
                  ret_d      = adv_ret;
                  outst_d    = (outst_q != '0) ? outst_q - COUNT_W'(1) : outst_q;
                end
              end
            end
            CMD_REG: begin
              push = 1'b1;
              if (!id_ok) begin
                res_status = STAT_INVALID;
              end else begin
                in_use_we    = 1'b1;
                in_use_wdata = 1'b1;
              end
            end
            CMD_QUERY: begin
              push = 1'b1;
              if (!id_ok) begin
                res_status = STAT_INVALID;
              end else if (!in_use_rd_q) begin
                res_status = STAT_NOT_USED;
              end
            end
            default: ;
          endcase
          if (push) begin
            state_d = S_IDLE;
          end
        end
      end

      S_WALK_RD: begin
        state_d = S_WALK_CHK;
      end

      S_WALK_CHK: begin
        if (out_free) begin
          if (slot_ok) begin
            push         = 1'b1;
            res_id       = ID_W'(slot_sum);
            ring_we      = 1'b1;
            in_use_we    = 1'b1;
            in_use_waddr = IW'(slot_sum);
            in_use_wdata = 1'b1;
            take_d       = adv_take;
            outst_d      = (outst_q != OUTST_MAX) ? outst_q + COUNT_W'(1) : outst_q;
            state_d      = S_IDLE;
          end else if (take_q == start_q) begin
            // full lap, pointer stays where the walk got to
            push       = 1'b1;
            res_status = STAT_FULL;
            state_d    = S_IDLE;
          end else begin
            take_d = adv_take;
            if (walk_cnt_q == RW'(RING_DEPTH - 1)) begin
              // walk bound hit without returning to the start
              push       = 1'b1;
              res_status = STAT_FULL;
              state_d    = S_IDLE;
            end else begin
              walk_cnt_d = walk_cnt_q + RW'(1);
              state_d    = S_WALK_RD;
            end
          end
        end
      end

      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      take_q     <= RW'(1);
      ret_q      <= RW'(1);
      start_q    <= RW'(1);
      walk_cnt_q <= '0;
      outst_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      take_q     <= take_d;
      ret_q      <= ret_d;
      start_q    <= start_d;
      walk_cnt_q <= walk_cnt_d;
      outst_q    <= outst_d;
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // command latch
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q <= cmd_e'(s_axis_tdata[S_CMD_LSB +: CMD_W]);
      id_q  <= s_axis_tdata[S_ID_LSB +: ID_W];
    end
  end

  // result register, counts taken after the command
  always_ff @(posedge clk_i) begin
    if (push) begin
      m_status_q <= res_status;
      m_id_q     <= res_id;
      m_use_q    <= outst_d;
      m_free_q   <= (cap_q > outst_d) ? cap_q - outst_d : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - M_FREE_LSB - COUNT_W)'(0),
                          m_free_q, m_use_q, m_id_q, m_status_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `DIRA_ASSERT_NEXT(a_accept_to_exec, s_accept, state_q == S_EXEC, "accepted item did not reach execute")
  `DIRA_ASSERT_NOW(a_result_source, $rose(m_valid_q), ($past(state_q) == S_EXEC) || ($past(state_q) == S_WALK_CHK), "result raised outside execute or walk check")
  `DIRA_ASSERT_NOW(a_alloc_above_base, push && (res_status == STAT_OK) && (res_id != '0), res_id > base_q, "allocated id not above the base")
  `DIRA_ASSERT_NEXT(a_clear_once, state_q != S_CLEAR, state_q != S_CLEAR, "clearing pass re-entered")

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench of the dialog id ring allocator
`timescale 1ns / 1ps

module tb;
  import dira_pkg::*;

  localparam int unsigned DEPTH    = 4096;
  localparam int unsigned RING_N   = DEPTH / 2 + 1;
  localparam int unsigned HELD_MAX = 4095;
  // slowest legal run: clearing pass, then every allocate walking the whole ring through
  // walk read and walk check per entry, longest stalls on both sides, taken several times over
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  // reply fields, msb first so that the struct lines up with m_axis_tdata
  typedef struct packed {
    logic [COUNT_W-1:0] free_cnt;
    logic [COUNT_W-1:0] used_cnt;
    logic [ID_W-1:0]    aid;
    status_e            st;
  } verdict_t;

  // one row of the directed part; typed rows carry status and id read off by hand
  typedef struct packed {
    cmd_e            op;
    logic [ID_W-1:0] id;
    logic            typed;
    status_e         st;
    logic [ID_W-1:0] aid;
  } row_t;

  // directed part, run at the reset setting: pool 4096, shift 0, base 2048, ring of 2048
  localparam int PLAN_N = 25;
  localparam row_t PLAN [0:PLAN_N-1] = '{
    '{CMD_QUERY, 13'd0,      1'b1, STAT_INVALID,  13'd0},    // id zero on query, free and register
    '{CMD_FREE,  13'd0,      1'b1, STAT_INVALID,  13'd0},
    '{CMD_REG,   13'd0,      1'b1, STAT_INVALID,  13'd0},
    '{CMD_QUERY, 13'd4097,   1'b1, STAT_INVALID,  13'd0},    // just above the pool
    '{CMD_FREE,  13'd8191,   1'b1, STAT_INVALID,  13'd0},    // all ones
    '{CMD_REG,   13'd4097,   1'b1, STAT_INVALID,  13'd0},
    '{CMD_QUERY, 13'd1,      1'b1, STAT_NOT_USED, 13'd0},    // nothing in use yet
    '{CMD_FREE,  13'd4096,   1'b1, STAT_NOT_USED, 13'd0},
    '{CMD_ALLOC, 13'd0,      1'b1, STAT_OK,       13'd2049}, // slot 1 plus base
    '{CMD_ALLOC, 13'd8191,   1'b1, STAT_OK,       13'd2050}, // id ignored on allocate
    '{CMD_QUERY, 13'd2049,   1'b1, STAT_OK,       13'd0},
    '{CMD_FREE,  13'd2049,   1'b1, STAT_OK,       13'd0},
    '{CMD_FREE,  13'd2049,   1'b1, STAT_NOT_USED, 13'd0},    // double free
    '{CMD_REG,   13'd1,      1'b1, STAT_OK,       13'd0},
    '{CMD_REG,   13'd1,      1'b1, STAT_OK,       13'd0},    // register twice
    '{CMD_QUERY, 13'd1,      1'b1, STAT_OK,       13'd0},
    '{CMD_FREE,  13'd1,      1'b1, STAT_OK,       13'd0},    // lower range, ring untouched
    '{CMD_QUERY, 13'd1,      1'b1, STAT_NOT_USED, 13'd0},
    '{CMD_REG,   13'd4096,   1'b1, STAT_OK,       13'd0},    // upper range registered
    '{CMD_FREE,  13'd4096,   1'b1, STAT_OK,       13'd0},
    '{CMD_REG,   13'd4095,   1'b1, STAT_OK,       13'd0},
    '{CMD_FREE,  13'd4095,   1'b1, STAT_OK,       13'd0},    // outstanding stays at zero
    '{CMD_ALLOC, 13'd0,      1'b0, STAT_OK,       13'd0},    // takes a returned slot
    '{CMD_QUERY, 13'h1555,   1'b1, STAT_INVALID,  13'd0},
    '{CMD_ALLOC, 13'h0aaa,   1'b0, STAT_OK,       13'd0}
  };

  // random phases: setting and item count; a zero pool picks a random setting
  localparam int PHASES = 8;
  localparam int unsigned PH_POOL  [PHASES] = '{4096, 16, 2, 8,    4096, 100, 4096, 0};
  localparam int unsigned PH_SHIFT [PHASES] = '{0,    3,  0, 2047, 2047, 10,  0,    0};
  localparam int unsigned PH_ITEMS [PHASES] = '{80,   60, 25, 15,  35,   70,  70,   50};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // cmd, dlg_id, zero pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // status, alloc_id, in_use_count, free_count, zero pad

  dialog_id_ring_allocator #(
    .POOL_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // allocator state as the testbench sees it
  // ------------------------------------------------------------------
  logic [COUNT_W-1:0] slot_ring [RING_N];   // 0 marks an emptied entry
  logic               id_busy [DEPTH+1];
  int unsigned        take_idx, back_idx, held;
  int unsigned        pool_reg, shift_reg;

  verdict_t        replies_due [$];   // replies still owed by the block, oldest first
  logic [ID_W-1:0] live_ids [$];      // ids handed out or registered, for well-formed frees
  int unsigned     mismatches = 0;
  int unsigned     cycles = 0;
  int unsigned     burst_left = 0;

  initial begin
    for (int i = 0; i < RING_N; i++) slot_ring[i] = COUNT_W'(i);
    for (int i = 0; i <= DEPTH; i++) id_busy[i] = 1'b0;
    take_idx  = 1;
    back_idx  = 1;
    held      = 0;
    pool_reg  = DEPTH;
    shift_reg = 0;
  end

  // register values beyond their useful range act as the range limit
  function automatic int unsigned pool_now();
    return (pool_reg > DEPTH) ? DEPTH : pool_reg;
  endfunction

  function automatic int unsigned shift_now();
    return (shift_reg > pool_now() / 2) ? pool_now() / 2 : shift_reg;
  endfunction

  function automatic int unsigned base_now();
    return pool_now() / 2 + shift_now();
  endfunction

  function automatic int unsigned cap_now();
    return pool_now() / 2 - shift_now();
  endfunction

  // both ring pointers wrap from the capacity (or the ring end) back to slot 1
  function automatic int unsigned step_slot(input int unsigned p, input int unsigned cap);
    return (p + 1 > cap || p + 1 >= RING_N) ? 1 : p + 1;
  endfunction

  // an entry is usable unless emptied or stale under the current setting
  function automatic logic slot_live(input int unsigned p);
    if (p >= RING_N) return 1'b0;
    return slot_ring[p] != '0 && slot_ring[p] + base_now() <= pool_now();
  endfunction

  task automatic grab_id(output status_e st, output logic [ID_W-1:0] got);
    int unsigned cap, origin, n;
    logic        hit, stop;
    cap  = cap_now();
    st   = STAT_OK;
    got  = '0;
    hit  = 1'b1;
    stop = 1'b0;
    if (cap == 0) begin
      st = STAT_FULL;
      return;
    end
    if (!slot_live(take_idx)) begin
      if (held >= cap) begin
        st = STAT_FULL;
        return;
      end
      // skip walk: a lap back to the start, or a bounded number of entries,
      // finds nothing; the take pointer keeps where the walk ended
      hit    = 1'b0;
      origin = take_idx;
      take_idx = step_slot(take_idx, cap);
      n = 0;
      while (!hit && !stop) begin
        if (slot_live(take_idx)) begin
          hit = 1'b1;
        end else if (take_idx == origin) begin
          stop = 1'b1;
        end else begin
          take_idx = step_slot(take_idx, cap);
          n++;
          if (n == RING_N) stop = 1'b1;
        end
      end
      if (!hit) begin
        st = STAT_FULL;
        return;
      end
    end
    got = ID_W'(slot_ring[take_idx] + base_now());
    slot_ring[take_idx] = '0;
    take_idx = step_slot(take_idx, cap);
    if (held < HELD_MAX) held++;
    id_busy[got] = 1'b1;
  endtask

  task automatic drop_id(input logic [ID_W-1:0] id, output status_e st);
    int unsigned base;
    base = base_now();
    st   = STAT_OK;
    if (id < 1 || id > pool_now()) begin
      st = STAT_INVALID;
    end else if (!id_busy[id]) begin
      st = STAT_NOT_USED;
    end else begin
      id_busy[id] = 1'b0;
      // only upper-range ids go back into the ring
      if (id > base) begin
        if (back_idx < RING_N) slot_ring[back_idx] = COUNT_W'(id - base);
        back_idx = step_slot(back_idx, cap_now());
        if (held > 0) held--;
      end
    end
  endtask

  // reply of the allocator to one command, state updated along the way
  task automatic allocator_reply(input cmd_e op, input logic [ID_W-1:0] id,
                                 output verdict_t v);
    status_e         st;
    logic [ID_W-1:0] got;
    int unsigned     cap;
    st  = STAT_OK;
    got = '0;
    case (op)
      CMD_ALLOC: begin
        grab_id(st, got);
      end
      CMD_FREE: begin
        drop_id(id, st);
      end
      CMD_REG: begin
        if (id < 1 || id > pool_now()) st = STAT_INVALID;
        else id_busy[id] = 1'b1;
      end
      default: begin
        if (id < 1 || id > pool_now()) st = STAT_INVALID;
        else if (!id_busy[id]) st = STAT_NOT_USED;
      end
    endcase
    cap        = cap_now();
    v.st       = st;
    v.aid      = got;
    v.used_cnt = COUNT_W'(held);
    v.free_cnt = COUNT_W'(cap > held ? cap - held : 0);
  endtask

  // ------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------

  // bursts of random length with random gaps, now and then a long burst
  task automatic pace();
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // hands one item to the block and books the reply it owes
  task automatic push_cmd(input cmd_e op, input logic [ID_W-1:0] id, input logic typed,
                          input status_e st, input logic [ID_W-1:0] aid);
    verdict_t v;
    int       hit_at;
    pace();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    allocator_reply(op, id, v);
    if (typed) begin
      v.st  = st;
      v.aid = aid;
    end
    replies_due.push_back(v);
    // keep track of ids that a later free can hit
    if (v.st == STAT_OK) begin
      if (op == CMD_ALLOC) live_ids.push_back(v.aid);
      else if (op == CMD_REG) live_ids.push_back(id);
      else if (op == CMD_FREE) begin
        hit_at = -1;
        for (int i = 0; i < live_ids.size(); i++)
          if (hit_at < 0 && live_ids[i] == id) hit_at = i;
        if (hit_at >= 0) live_ids.delete(hit_at);
      end
    end
  endtask

  // mostly ids in use, then any valid id, the range edges, and raw 13-bit noise
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned p;
    p = pool_now();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (live_ids.size() != 0) return live_ids[$urandom_range(0, live_ids.size() - 1)];
        return ID_W'($urandom_range(1, p));
      end
      5, 6, 7: begin
        return ID_W'($urandom_range(1, p));
      end
      8: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return ID_W'(1);
          2: return ID_W'(p);
          default: return ID_W'(p + 1);
        endcase
      end
      default: begin
        return ID_W'($urandom);
      end
    endcase
  endfunction

  // hold the sender until every reply is in, then give the block time to go idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_setting(input int unsigned pool, input int unsigned shift);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POOL_SIZE;
    cfg_data_i <= CFG_DATA_W'(pool);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHIFT;
    cfg_data_i <= CFG_DATA_W'(shift);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pool_reg  = pool & 32'h1fff;
    shift_reg = shift & 32'h7ff;
  endtask

  // ------------------------------------------------------------------
  // receiver side: its own stall pattern, long ready stretches included
  // ------------------------------------------------------------------
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          m_axis_tready <= 1'b0;
          hold_left = $urandom_range(1, 6);
        end
        1: begin
          m_axis_tready <= 1'b1;
          hold_left = $urandom_range(40, 120);
        end
        default: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
          hold_left = $urandom_range(1, 3);
        end
      endcase
    end else begin
      hold_left--;
    end
  end

  // ------------------------------------------------------------------
  // reply checking, oldest expectation first
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : check_replies
    verdict_t want, seen;
    if (m_axis_tvalid && m_axis_tready) begin
      seen = verdict_t'(m_axis_tdata[M_FREE_LSB+COUNT_W-1:0]);
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: reply with none expected, actual %h", $time, m_axis_tdata);
      end else begin
        want = replies_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          $display("%0t: reply mismatch, expected status %0d id %0d used %0d free %0d",
                   $time, want.st, want.aid, want.used_cnt, want.free_cnt);
          $display("%0t:                 actual   status %0d id %0d used %0d free %0d",
                   $time, seen.st, seen.aid, seen.used_cnt, seen.free_cnt);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dialog_id_ring_allocator test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  initial begin : stimulus
    logic [ID_W-1:0] drain_ids [$];
    cmd_e            op;
    int unsigned     r, pool_w, shift_w;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_POOL_SIZE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items at the reset setting; the clearing pass holds tready low
    for (int i = 0; i < PLAN_N; i++)
      push_cmd(PLAN[i].op, PLAN[i].id, PLAN[i].typed, PLAN[i].st, PLAN[i].aid);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        // hand back everything still held so the new setting starts near empty,
        // while stale entries from the old setting stay in the ring
        drain_ids = live_ids;
        foreach (drain_ids[i]) push_cmd(CMD_FREE, drain_ids[i], 1'b0, STAT_OK, '0);
        live_ids.delete();
        settle();
        if (PH_POOL[ph] == 0) begin
          pool_w  = $urandom_range(2, DEPTH);
          shift_w = $urandom_range(0, pool_w / 2);
        end else begin
          pool_w  = PH_POOL[ph];
          shift_w = PH_SHIFT[ph];
        end
        load_setting(pool_w, shift_w);
      end
      for (int n = 0; n < PH_ITEMS[ph]; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) op = CMD_ALLOC;
        else if (r < 65) op = CMD_FREE;
        else if (r < 80) op = CMD_REG;
        else op = CMD_QUERY;
        push_cmd(op, pick_id(), 1'b0, STAT_OK, '0);
      end
    end

    // wait for the last replies, then a little longer for anything stray
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("dialog_id_ring_allocator test passed");
    end else begin
      $display("dialog_id_ring_allocator test failed");
    end
    $finish;
  end

endmodule
